// File: src/ace_pkg.sv
// Shared types and constants of the 31-bit arithmetic encoder.
`default_nettype none

package ace_pkg;

    // Bounds of the coding interval.
    localparam logic [30:0] Q1     = 31'h2000_0000;
    localparam logic [30:0] HALF   = 31'h4000_0000;
    localparam logic [30:0] Q3     = 31'h6000_0000;
    localparam logic [30:0] MASK31 = 31'h7FFF_FFFF;

    // Bytes kept for one input item; later bytes of the same item are dropped.
    localparam int RES_MAX = 40;
    localparam int RES_AW  = $clog2(RES_MAX);
    localparam int RES_CW  = $clog2(RES_MAX + 1);

    localparam int CNT_W = 29;

    typedef struct packed {
        logic             mode;
        logic [CNT_W-1:0] cum_low;
        logic [CNT_W-1:0] cum_high;
        logic [CNT_W-1:0] total_count;
    } ace_item_t;

    // Summary handed from the encoder core to the result drain.
    typedef struct packed {
        logic              done;
        logic              err;
        logic              sat;
        logic [RES_CW-1:0] count;
    } ace_done_t;

endpackage

`default_nettype wire

// File: src/ace_in_if.sv
// Symbol channel: valid/ready handshake with the symbol item payload.
`default_nettype none

interface ace_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [28:0] cum_low;
    logic [28:0] cum_high;
    logic [28:0] total_count;

    modport source (output valid, output mode, output cum_low, output cum_high,
                    output total_count, input ready);
    modport sink (input valid, input mode, input cum_low, input cum_high,
                  input total_count, output ready);
endinterface

`default_nettype wire

// File: src/ace_out_if.sv
// Result channel: valid/ready handshake with the result item payload.
`default_nettype none

interface ace_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    logic       error;
    logic       pending_saturated;

    modport source (output valid, output out_byte, output byte_valid, output last,
                    output error, output pending_saturated, input ready);
    modport sink (input valid, input out_byte, input byte_valid, input last,
                  input error, input pending_saturated, output ready);
endinterface

`default_nettype wire

// File: src/ace_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ace_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 40
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// File: src/ace_div.sv
// Restoring divider: one quotient bit per cycle; done rises after the last quotient bit is shifted in.
`default_nettype none

module ace_div
    import ace_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [31:0]      dividend,
    input  wire logic [CNT_W-1:0] divisor,
    output logic                  done,
    output logic      [31:0]      quotient
);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [4:0]       step_reg, step_next;
    logic [31:0]      q_reg, q_next;
    logic [CNT_W-1:0] rem_reg, rem_next;
    logic [CNT_W:0]   trial;
    logic [CNT_W:0]   diff;
    logic             ge;

    assign trial = {rem_reg, q_reg[31]};
    assign diff  = trial - {1'b0, divisor};
    assign ge    = (trial >= {1'b0, divisor});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = 5'd0;
            q_next    = dividend;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            q_next    = {q_reg[30:0], ge};
            rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            step_next = step_reg + 5'd1;
            if (step_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

`default_nettype wire

// File: src/ace_core.sv
// Encoder sequencer: interval narrowing, renormalization, bit packing, finish.
`default_nettype none

module ace_core
    import ace_pkg::*;
#(
    parameter int PENDING_MAX = 255
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire ace_item_t         item,
    output logic                   idle,
    output ace_done_t              status,
    output logic                   wr_en,
    output logic      [RES_AW-1:0] wr_addr,
    output logic      [7:0]        wr_data
);

    localparam int PEND_W = $clog2(PENDING_MAX + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DIV    = 4'd1;
    localparam logic [3:0] S_MULH   = 4'd2;
    localparam logic [3:0] S_MULL   = 4'd3;
    localparam logic [3:0] S_BOUND  = 4'd4;
    localparam logic [3:0] S_RENORM = 4'd5;
    localparam logic [3:0] S_PEND   = 4'd6;
    localparam logic [3:0] S_FIN    = 4'd7;
    localparam logic [3:0] S_FONE   = 4'd8;
    localparam logic [3:0] S_PAD    = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0]        state_reg, state_next;
    logic [30:0]       low_reg, low_next;
    logic [30:0]       high_reg, high_next;
    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [7:0]        pb_reg, pb_next;
    logic [2:0]        pc_reg, pc_next;
    logic [RES_CW-1:0] cnt_reg, cnt_next;
    logic              sat_reg, sat_next;
    logic              err_reg, err_next;
    logic              pbit_reg, pbit_next;
    logic [CNT_W-1:0]  lc_reg, hc_reg, tc_reg;
    logic [31:0]       prod_reg, prod_next;

    logic              div_start;
    logic              div_done;
    logic [31:0]       step;
    logic [31:0]       span;
    logic [CNT_W-1:0]  mul_op;
    logic [31:0]       mul_out;
    logic              put_en;
    logic              put_val;
    logic              bad_item;
    logic [30:0]       low_dbl;
    logic [30:0]       high_dbl;

    assign span = {1'b0, high_reg} - {1'b0, low_reg} + 32'd1;

    ace_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (span),
        .divisor  (tc_reg),
        .done     (div_done),
        .quotient (step)
    );

    // One multiplier serves both bounds; the product never exceeds the span.
    assign mul_op  = (state_reg == S_MULH) ? hc_reg : lc_reg;
    assign mul_out = 32'(step * mul_op);

    assign bad_item = (item.total_count == '0) || (item.cum_low >= item.cum_high) ||
                      (item.cum_high > item.total_count);

    assign low_dbl  = {low_reg[29:0], 1'b0};
    assign high_dbl = {high_reg[29:0], 1'b1};

    always_comb
    begin
        state_next = state_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        pend_next  = pend_reg;
        pb_next    = pb_reg;
        pc_next    = pc_reg;
        cnt_next   = cnt_reg;
        sat_next   = sat_reg;
        err_next   = err_reg;
        pbit_next  = pbit_reg;
        prod_next  = prod_reg;
        div_start  = 1'b0;
        put_en     = 1'b0;
        put_val    = 1'b0;
        wr_en      = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cnt_next = '0;
                    sat_next = 1'b0;
                    err_next = 1'b0;
                    if (item.mode)
                    begin
                        state_next = S_FIN;
                    end
                    else if (bad_item)
                    begin
                        err_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DIV;
                        div_start  = 1'b1;
                    end
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_MULH;
                end
            end
            S_MULH:
            begin
                prod_next  = mul_out;
                state_next = S_MULL;
            end
            S_MULL:
            begin
                high_next  = 31'({1'b0, low_reg} + prod_reg - 32'd1);
                prod_next  = mul_out;
                state_next = S_BOUND;
            end
            S_BOUND:
            begin
                low_next   = 31'({1'b0, low_reg} + prod_reg);
                state_next = S_RENORM;
            end
            S_RENORM:
            begin
                if (high_reg < HALF || low_reg >= HALF)
                begin
                    // Both bounds in one half: emit the shared top bit.
                    put_en    = 1'b1;
                    put_val   = (high_reg >= HALF);
                    pbit_next = (high_reg < HALF);
                    low_next  = low_dbl;
                    high_next = high_dbl;
                    if (pend_reg != '0)
                    begin
                        state_next = S_PEND;
                    end
                end
                else if (low_reg >= Q1 && high_reg < Q3)
                begin
                    low_next  = low_dbl - HALF;
                    high_next = high_dbl - HALF;
                    if (pend_reg < PEND_W'(PENDING_MAX))
                    begin
                        pend_next = pend_reg + PEND_W'(1);
                    end
                    else
                    begin
                        sat_next = 1'b1;
                    end
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_PEND:
            begin
                put_en    = 1'b1;
                put_val   = pbit_reg;
                pend_next = pend_reg - PEND_W'(1);
                if (pend_reg == PEND_W'(1))
                begin
                    state_next = S_RENORM;
                end
            end
            S_FIN:
            begin
                put_en = 1'b1;
                if (low_reg < Q1)
                begin
                    put_val    = 1'b0;
                    state_next = S_FONE;
                end
                else
                begin
                    put_val    = 1'b1;
                    state_next = S_PAD;
                end
            end
            S_FONE:
            begin
                // Pending count plus one ones follow the leading zero.
                put_en  = 1'b1;
                put_val = 1'b1;
                if (pend_reg == '0)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    pend_next = pend_reg - PEND_W'(1);
                end
            end
            S_PAD:
            begin
                if (pc_reg == 3'd0)
                begin
                    low_next   = '0;
                    high_next  = MASK31;
                    pend_next  = '0;
                    state_next = S_DONE;
                end
                else
                begin
                    put_en  = 1'b1;
                    put_val = 1'b0;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // Bit packer: a full byte goes to the result buffer while it has room.
        if (put_en)
        begin
            pb_next = {pb_reg[6:0], put_val};
            pc_next = pc_reg + 3'd1;
            if (pc_reg == 3'd7)
            begin
                pb_next = '0;
                if (cnt_reg < RES_CW'(RES_MAX))
                begin
                    wr_en    = 1'b1;
                    cnt_next = cnt_reg + RES_CW'(1);
                end
            end
        end
    end

    assign wr_addr = cnt_reg[RES_AW-1:0];
    assign wr_data = {pb_reg[6:0], put_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            low_reg   <= '0;
            high_reg  <= MASK31;
            pend_reg  <= '0;
            pb_reg    <= '0;
            pc_reg    <= '0;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
            err_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            low_reg   <= low_next;
            high_reg  <= high_next;
            pend_reg  <= pend_next;
            pb_reg    <= pb_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            sat_reg   <= sat_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pbit_reg <= pbit_next;
        prod_reg <= prod_next;
        if (start && state_reg == S_IDLE)
        begin
            lc_reg <= item.cum_low;
            hc_reg <= item.cum_high;
            tc_reg <= item.total_count;
        end
    end

    assign idle         = (state_reg == S_IDLE);
    assign status.done  = (state_reg == S_DONE);
    assign status.err   = err_reg;
    assign status.sat   = sat_reg;
    assign status.count = cnt_reg;

endmodule

`default_nettype wire

// File: src/arith_encoder_31bit.sv
// Top level of the 31-bit arithmetic encoder: core, result buffer and result drain.
//
// Usage: symbol items arrive on the sym channel, result items leave on res.
// A transfer on sym happens when valid and ready are both high; ready is high
// only while the block holds no item. An encode item (mode 0) passes through
// the restoring divider, then the two products and the new bounds, then the
// renormalization shifts and the flushed pending bits, and a closing check. A
// finish item (mode 1) emits its bits up to the byte boundary and then closes.
// Bytes of an item are collected in a 40-entry buffer and handed out after the
// item completes, since the saturation flag and the last mark are known only
// then; each byte result passes a fetch state for the buffer read and a show
// state, a status-only result only the show state. A stalled receiver simply
// keeps the current result on res; no new symbol is taken until the last
// result of the item has been transferred. An item that yields no result frees
// the block in the cycle after its work ends. Reset puts the bounds at the full
// interval with no pending bits and an empty partial byte.
`default_nettype none

module arith_encoder_31bit
    import ace_pkg::*;
#(
    parameter int PENDING_MAX = 255
) (
    input wire logic clk,
    input wire logic rst_n,
    ace_in_if.sink   sym,
    ace_out_if.source res
);

    localparam logic [1:0] D_IDLE  = 2'd0;
    localparam logic [1:0] D_FETCH = 2'd1;
    localparam logic [1:0] D_SHOW  = 2'd2;

    logic              core_idle;
    logic              start;
    ace_item_t         item;
    ace_done_t         status;
    logic              wr_en;
    logic [RES_AW-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic [7:0]        rd_data;

    logic [1:0]        dst_reg, dst_next;
    logic [RES_AW-1:0] idx_reg, idx_next;
    logic [RES_CW-1:0] n_reg, n_next;
    logic              sat_reg, sat_next;
    logic              err_reg, err_next;
    logic              showb_reg, showb_next;
    logic              is_last;

    assign sym.ready = core_idle && (dst_reg == D_IDLE);
    assign start     = sym.valid && sym.ready;

    assign item.mode        = sym.mode;
    assign item.cum_low     = sym.cum_low;
    assign item.cum_high    = sym.cum_high;
    assign item.total_count = sym.total_count;

    ace_core #(
        .PENDING_MAX (PENDING_MAX)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .item    (item),
        .idle    (core_idle),
        .status  (status),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    ace_ram #(
        .WIDTH (8),
        .DEPTH (RES_MAX)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (idx_reg),
        .rdata (rd_data)
    );

    assign is_last = !showb_reg || ({1'b0, idx_reg} + (RES_AW+1)'(1) == (RES_AW+1)'(n_reg));

    always_comb
    begin
        dst_next   = dst_reg;
        idx_next   = idx_reg;
        n_next     = n_reg;
        sat_next   = sat_reg;
        err_next   = err_reg;
        showb_next = showb_reg;
        case (dst_reg)
            D_IDLE:
            begin
                if (status.done)
                begin
                    n_next   = status.count;
                    sat_next = status.sat && !status.err;
                    err_next = status.err;
                    idx_next = '0;
                    if (status.err || status.count == '0)
                    begin
                        // Error and saturation-only reports carry no byte.
                        showb_next = 1'b0;
                        if (status.err || status.sat)
                        begin
                            dst_next = D_SHOW;
                        end
                    end
                    else
                    begin
                        showb_next = 1'b1;
                        dst_next   = D_FETCH;
                    end
                end
            end
            D_FETCH:
            begin
                dst_next = D_SHOW;
            end
            D_SHOW:
            begin
                if (res.ready)
                begin
                    if (is_last)
                    begin
                        dst_next = D_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + RES_AW'(1);
                        dst_next = D_FETCH;
                    end
                end
            end
            default:
            begin
                dst_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dst_reg <= D_IDLE;
            idx_reg <= '0;
        end
        else
        begin
            dst_reg <= dst_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        sat_reg   <= sat_next;
        err_reg   <= err_next;
        showb_reg <= showb_next;
    end

    assign res.valid             = (dst_reg == D_SHOW);
    assign res.out_byte          = showb_reg ? rd_data : 8'd0;
    assign res.byte_valid        = showb_reg;
    assign res.last              = is_last;
    assign res.error             = err_reg;
    assign res.pending_saturated = sat_reg;

endmodule

`default_nettype wire
